// ===== sv/sfp_pkg.sv =====
// shared types, lookup tables and constants for the table sine block
`default_nettype none
package sfp_pkg;

    localparam int PHASE_W = 16;
    localparam int AMP_W   = 16;
    localparam int OUT_W   = 17;
    localparam int TRIG_W  = 16;
    localparam int CORR_W  = 16;
    localparam int RES_W   = 13;
    localparam int CIDX_W  = 5;
    localparam int RIDX_W  = 6;

    localparam logic [PHASE_W:0] HALF_STEP = 17'd1024;
    localparam logic [11:0]      RIDX_BIAS = 12'd32;
    localparam logic [CIDX_W-1:0] QUARTER  = 5'd8;

    // one classified request passed from front to back
    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
        logic        [CORR_W-1:0] d;
        logic signed [RES_W-1:0]  res;
    } sfp_item_t;

    // coarse sine, full scale pi * 2^13
    function automatic logic signed [TRIG_W-1:0] coarse_sine(input logic [CIDX_W-1:0] i);
        logic signed [TRIG_W-1:0] v;
        unique case (i)
            5'd0:  v = 16'sd0;
            5'd1:  v = 16'sd5021;
            5'd2:  v = 16'sd9849;
            5'd3:  v = 16'sd14298;
            5'd4:  v = 16'sd18198;
            5'd5:  v = 16'sd21399;
            5'd6:  v = 16'sd23777;
            5'd7:  v = 16'sd25241;
            5'd8:  v = 16'sd25736;
            5'd9:  v = 16'sd25241;
            5'd10: v = 16'sd23777;
            5'd11: v = 16'sd21399;
            5'd12: v = 16'sd18198;
            5'd13: v = 16'sd14298;
            5'd14: v = 16'sd9849;
            5'd15: v = 16'sd5021;
            5'd16: v = 16'sd0;
            5'd17: v = -16'sd5021;
            5'd18: v = -16'sd9849;
            5'd19: v = -16'sd14298;
            5'd20: v = -16'sd18198;
            5'd21: v = -16'sd21399;
            5'd22: v = -16'sd23777;
            5'd23: v = -16'sd25241;
            5'd24: v = -16'sd25736;
            5'd25: v = -16'sd25241;
            5'd26: v = -16'sd23777;
            5'd27: v = -16'sd21399;
            5'd28: v = -16'sd18198;
            5'd29: v = -16'sd14298;
            5'd30: v = -16'sd9849;
            default: v = -16'sd5021;
        endcase
        return v;
    endfunction

    // 2^17/pi * cos(residual)
    function automatic logic [CORR_W-1:0] cos_corr(input logic [RIDX_W-1:0] i);
        logic [CORR_W-1:0] v;
        unique case (i)
            6'd0:  v = 16'd41521;
            6'd1:  v = 16'd41545;
            6'd2:  v = 16'd41568;
            6'd3:  v = 16'd41589;
            6'd4:  v = 16'd41608;
            6'd5:  v = 16'd41627;
            6'd6:  v = 16'd41643;
            6'd7:  v = 16'd41658;
            6'd8:  v = 16'd41671;
            6'd9:  v = 16'd41683;
            6'd10: v = 16'd41693;
            6'd11: v = 16'd41702;
            6'd12: v = 16'd41709;
            6'd13: v = 16'd41714;
            6'd14: v = 16'd41718;
            6'd15: v = 16'd41721;
            6'd16: v = 16'd41722;
            6'd17: v = 16'd41721;
            6'd18: v = 16'd41718;
            6'd19: v = 16'd41714;
            6'd20: v = 16'd41709;
            6'd21: v = 16'd41702;
            6'd22: v = 16'd41693;
            6'd23: v = 16'd41683;
            6'd24: v = 16'd41671;
            6'd25: v = 16'd41658;
            6'd26: v = 16'd41643;
            6'd27: v = 16'd41627;
            6'd28: v = 16'd41608;
            6'd29: v = 16'd41589;
            6'd30: v = 16'd41568;
            6'd31: v = 16'd41545;
            default: v = 16'd41521;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/sine_from_phase_table_interp.sv =====
// Table sine with angle-addition correction, scaled by a Q15 amplitude.
// A phase request is accepted on every cycle that full is low, and one signed
// 17-bit result comes out per request, in order, at a sustained rate of one
// per clock while pop is held high. The front register does the coarse-angle
// split and the table lookups, a queue decouples it from the back pipeline
// (two products, round, amplitude product, round and clip over three register
// stages), and a result queue holds finished values until popped. A result
// passes the front register, the middle queue, the three back stages and the
// result queue in that order. amplitude is taken on any cycle (cfg_ready is
// always high) and should be changed only while no request is in flight.
`default_nettype none
module sine_from_phase_table_interp
    import sfp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [PHASE_W-1:0] phase,
    output logic                    empty,
    input  wire logic               pop,
    output logic      [OUT_W-1:0]   sine_out,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [AMP_W-1:0]   cfg_data
);

    logic [AMP_W-1:0] amplitude_reg, amplitude_next;
    logic             f_push, f_full;
    sfp_item_t        f_item;
    logic             m_empty, m_pop;
    sfp_item_t        m_item;
    logic             o_push, o_full;
    logic [OUT_W-1:0] o_data;

    assign cfg_ready      = 1'b1;
    assign amplitude_next = (cfg_valid && cfg_ready) ? cfg_data : amplitude_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= 16'd32768;
        end
        else
        begin
            amplitude_reg <= amplitude_next;
        end
    end

    sfp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .phase  (phase),
        .q_push (f_push),
        .q_full (f_full),
        .q_item (f_item)
    );

    sfp_fifo #(
        .WIDTH ($bits(sfp_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .full  (f_full),
        .wdata (f_item),
        .pop   (m_pop),
        .empty (m_empty),
        .rdata (m_item)
    );

    sfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (m_empty),
        .q_item    (m_item),
        .q_pop     (m_pop),
        .amplitude (amplitude_reg),
        .o_push    (o_push),
        .o_full    (o_full),
        .o_data    (o_data)
    );

    sfp_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .full  (o_full),
        .wdata (o_data),
        .pop   (pop),
        .empty (empty),
        .rdata (sine_out)
    );

endmodule
`default_nettype wire

// ===== sv/sfp_fifo.sv =====
// small first-in first-out queue with push/full and pop/empty sides
`default_nettype none
module sfp_fifo
    import sfp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic                  empty,
    output logic      [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on push");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on pop");

endmodule
`default_nettype wire

// ===== sv/sfp_front.sv =====
// front end: splits the phase into coarse angle and residual, looks up the tables
`default_nettype none
module sfp_front
    import sfp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [PHASE_W-1:0] phase,
    output logic                    q_push,
    input  wire logic               q_full,
    output sfp_item_t               q_item
);

    logic             valid_reg, valid_next;
    sfp_item_t        item_reg, item_next;
    logic             accept, advance;
    logic [PHASE_W:0] t;
    logic [CIDX_W-1:0] cidx;
    logic [11:0]      rsum;
    logic [RIDX_W-1:0] ridx;

    assign advance = !valid_reg || !q_full;
    assign full    = !advance;
    assign accept  = push && advance;
    assign q_push  = valid_reg;
    assign q_item  = item_reg;

    always_comb
    begin
        // round to the nearest of 32 coarse angles; index 32 wraps to 0
        t    = {1'b0, phase} + HALF_STEP;
        cidx = t[PHASE_W-1:11];
        rsum = {1'b0, t[10:0]} + RIDX_BIAS;
        ridx = rsum[11:6];

        item_next.s   = coarse_sine(cidx);
        item_next.c   = coarse_sine(cidx + QUARTER);
        item_next.d   = cos_corr(ridx);
        // residual times four, low bits of t offset by half a step
        item_next.res = {~t[10], t[9:0], 2'b00};

        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/sfp_back.sv =====
// back end: angle-addition products, rounding, amplitude scaling and saturation
`default_nettype none
module sfp_back
    import sfp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire sfp_item_t        q_item,
    output logic                  q_pop,
    input  wire logic [AMP_W-1:0] amplitude,
    output logic                  o_push,
    input  wire logic             o_full,
    output logic      [OUT_W-1:0] o_data
);

    logic               va_reg, vb_reg, vc_reg;
    logic               adv;
    logic signed [32:0] p_sd_reg, p_sd_next;
    logic signed [28:0] p_cr_reg, p_cr_next;
    logic signed [33:0] sum_b;
    logic signed [18:0] acc_reg, acc_next;
    logic signed [35:0] prod_reg, prod_next;
    logic signed [36:0] sum_d;
    logic signed [21:0] v_d;

    assign adv   = !vc_reg || !o_full;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        p_sd_next = q_item.s * $signed({1'b0, q_item.d});
        p_cr_next = q_item.c * q_item.res;

        sum_b    = 34'(p_sd_reg) + 34'(p_cr_reg) + 34'sd16384;
        acc_next = sum_b[33:15];

        prod_next = acc_reg * $signed({1'b0, amplitude});

        sum_d = 37'(prod_reg) + 37'sd16384;
        v_d   = sum_d[36:15];
        // clip to the 17-bit range
        if (v_d > 22'sd65535)
        begin
            o_data = 17'h0FFFF;
        end
        else if (v_d < -22'sd65536)
        begin
            o_data = 17'h10000;
        end
        else
        begin
            o_data = v_d[OUT_W-1:0];
        end
    end

    assign o_push = vc_reg && !o_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= !q_empty;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_sd_reg <= p_sd_next;
            p_cr_reg <= p_cr_next;
            acc_reg  <= acc_next;
            prod_reg <= prod_next;
        end
    end

endmodule
`default_nettype wire
